// ----- rtl/core/superio_config_register_file_macros.svh -----
// Assertion macros shared by the checker of the configuration register file.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SUPERIO_CONFIG_REGISTER_FILE_MACROS_SVH
`define SUPERIO_CONFIG_REGISTER_FILE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/scrf_pkg.sv -----
// Package of the configuration register file: sizes, special bytes, controller
// types and the reset-default and write-guard functions.
// No dependencies.
`default_nettype none

package scrf_pkg;

  // Store sizes.
  localparam int GLOBAL_REG_COUNT = 48;
  localparam int DEVICE_COUNT     = 10;
  localparam int GLB_AW           = $clog2(GLOBAL_REG_COUNT);
  localparam int DEV_DEPTH        = DEVICE_COUNT * 256;
  localparam int DEV_AW           = $clog2(DEV_DEPTH);
  localparam int DEV_BITS         = DEV_AW - 8;

  // Special bytes on the ports.
  localparam logic [7:0] UNLOCK_BYTE = 8'h55;
  localparam logic [7:0] LOCK_BYTE   = 8'hAA;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] REG3_MASK   = 8'h83;

  // Global register indexes with special handling.
  localparam logic [7:0] IDX_POWER   = 8'h03;
  localparam logic [7:0] IDX_DEVSEL  = 8'h07;
  localparam logic [7:0] IDX_CHIP_ID = 8'h20;
  localparam logic [7:0] IDX_CHIP_RV = 8'h21;

  // Variant that carries logical device 9.
  localparam logic [1:0] VARIANT_FULL = 2'd3;

  // Access codes.
  localparam logic CMD_READ   = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } scrf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the access and start the memory reads
    logic exec;      // apply the access and load the result register
    logic clear_wr;  // write one default entry of the device store
  } scrf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last entry
  } scrf_sts_t;

  // Reset value of a global register.
  function automatic logic [7:0] glb_default(input logic [GLB_AW-1:0] idx);
    logic [7:0] val;
    case (8'(idx))
      8'h03:   val = 8'h03;
      8'h20:   val = 8'h03;
      8'h21:   val = 8'h01;
      8'h22:   val = 8'h39;
      8'h24:   val = 8'h04;
      8'h26:   val = 8'hF0;
      8'h27:   val = 8'h03;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Reset value of one entry of the banked device store.
  function automatic logic [7:0] dev_default(input logic [DEV_AW-1:0] addr);
    logic [7:0] dv;
    logic [7:0] rg;
    logic [7:0] val;
    dv = 8'(addr[DEV_AW-1:8]);
    rg = addr[7:0];
    case ({dv, rg})
      16'h0030: val = 8'h01;
      16'h0060: val = 8'h03;
      16'h0061: val = 8'hF0;
      16'h0070: val = 8'h06;
      16'h0074: val = 8'h02;
      16'h00F0: val = 8'h0E;
      16'h00F2: val = 8'hFF;
      16'h0160: val = 8'h01;
      16'h0161: val = 8'hF0;
      16'h0162: val = 8'h03;
      16'h0163: val = 8'hF6;
      16'h0170: val = 8'h0E;
      16'h01F0: val = 8'h0C;
      16'h0260: val = 8'h01;
      16'h0261: val = 8'h70;
      16'h0262: val = 8'h03;
      16'h0263: val = 8'h76;
      16'h0270: val = 8'h0F;
      16'h0330: val = 8'h01;
      16'h0360: val = 8'h03;
      16'h0361: val = 8'h78;
      16'h0370: val = 8'h07;
      16'h0374: val = 8'h04;
      16'h03F0: val = 8'h3C;
      16'h0430: val = 8'h01;
      16'h0460: val = 8'h03;
      16'h0461: val = 8'hF8;
      16'h0470: val = 8'h04;
      16'h04F0: val = 8'h03;
      16'h0530: val = 8'h01;
      16'h0560: val = 8'h02;
      16'h0561: val = 8'hF8;
      16'h0570: val = 8'h03;
      16'h0574: val = 8'h04;
      16'h05F1: val = 8'h02;
      16'h05F2: val = 8'h03;
      16'h0663: val = 8'h70;
      16'h06F4: val = 8'h03;
      16'h0730: val = 8'h01;
      16'h0761: val = 8'h60;
      16'h0770: val = 8'h01;
      default:  val = 8'h00;
    endcase
    return val;
  endfunction

  // True when a write to a device register must be dropped.
  function automatic logic dev_write_blocked(input logic [7:0] dev, input logic [7:0] rg,
                                             input logic [1:0] variant);
    logic blk;
    blk = 1'b0;
    if (dev >= 8'(DEVICE_COUNT)) blk = 1'b1;
    if (rg[7:4] == 4'h7 && dev < 8'd4) blk = 1'b1;
    if (dev == 8'd1 || dev == 8'd2 || dev == 8'd6 || dev == 8'd7) blk = 1'b1;
    if (dev == 8'd9 && variant != VARIANT_FULL) blk = 1'b1;
    return blk;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scrf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scrf_ctrl.sv -----
// Controller of the configuration register file: clearing pass, access
// sequencing and the result valid flag. Depends on scrf_pkg.
`default_nettype none

module scrf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output      logic                item_stall,
  output      logic                result_valid,
  input  wire logic                result_stall,
  output      scrf_pkg::scrf_cmd_t cmd,
  input  wire scrf_pkg::scrf_sts_t sts
);

  import scrf_pkg::*;

  scrf_state_t state;
  scrf_state_t state_next;
  logic        out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= cmd.exec || (result_valid && result_stall);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scrf_dpath.sv -----
// Datapath of the configuration register file: mode and index registers,
// global and device stores, and the result register. Depends on scrf_pkg
// and scrf_ram.
`default_nettype none

module scrf_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scrf_pkg::scrf_cmd_t cmd,
  output      scrf_pkg::scrf_sts_t sts,
  input  wire logic                chip_variant_we,
  input  wire logic [1:0]          chip_variant_wdata,
  input  wire logic                command,
  input  wire logic                port_select,
  input  wire logic [7:0]          write_data,
  output      logic [7:0]          read_data,
  output      logic                config_open
);

  import scrf_pkg::*;

  // Captured access.
  logic        cmd_q;
  logic        port_q;
  logic [7:0]  wdata_q;

  // Control registers.
  logic [1:0]  chip_variant;
  logic        mode_open;
  logic        mode_open_next;
  logic        unlock_seen;
  logic [7:0]  index_reg;
  logic [7:0]  dev_sel;
  logic [GLOBAL_REG_COUNT-1:0] glb_valid;
  logic [DEV_AW-1:0] clr_cnt;

  // Decode.
  logic              is_glb;
  logic              dev_in_range;
  logic [GLB_AW-1:0] glb_addr;
  logic [DEV_AW-1:0] dev_addr;
  logic              is_wr;
  logic              data_wr;
  logic              glb_we;
  logic [7:0]        glb_wdata;
  logic [7:0]        glb_rdata;
  logic [7:0]        glb_value;
  logic              dev_we;
  logic [DEV_AW-1:0] dev_waddr;
  logic [7:0]        dev_wdata;
  logic [7:0]        dev_rdata;
  logic [7:0]        rd_value;

  assign is_glb       = index_reg < 8'(GLOBAL_REG_COUNT);
  assign dev_in_range = dev_sel < 8'(DEVICE_COUNT);
  assign glb_addr     = index_reg[GLB_AW-1:0];
  assign dev_addr     = {dev_sel[DEV_BITS-1:0], index_reg};
  assign is_wr        = (cmd_q == CMD_WRITE);
  assign data_wr      = cmd.exec && is_wr && port_q == PORT_DATA && mode_open;

  // Capture the access on its transfer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q   <= command;
      port_q  <= port_select;
      wdata_q <= write_data;
    end
  end

  // Chip variant register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_variant <= VARIANT_FULL;
    end else if (chip_variant_we) begin
      chip_variant <= chip_variant_wdata;
    end
  end

  // Mode sequencing on index writes.
  always_comb begin
    mode_open_next = mode_open;
    if (cmd.exec && is_wr && port_q == PORT_INDEX && mode_open && wdata_q == LOCK_BYTE) begin
      mode_open_next = 1'b0;
    end else if (cmd.exec && is_wr && port_q == PORT_INDEX && !mode_open &&
                 wdata_q == UNLOCK_BYTE && unlock_seen) begin
      mode_open_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_open   <= 1'b0;
      unlock_seen <= 1'b0;
      index_reg   <= '0;
    end else begin
      mode_open <= mode_open_next;
      if (cmd.exec && is_wr && port_q == PORT_INDEX) begin
        if (!mode_open) begin
          unlock_seen <= (wdata_q == UNLOCK_BYTE) && !unlock_seen;
        end else if (wdata_q != LOCK_BYTE) begin
          index_reg <= wdata_q;
        end
      end
    end
  end

  // Global store: written entries are marked valid, others read as default.
  assign glb_we    = data_wr && is_glb && index_reg != IDX_CHIP_ID && index_reg != IDX_CHIP_RV;
  assign glb_wdata = (index_reg == IDX_POWER) ? (wdata_q & REG3_MASK) : wdata_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      glb_valid <= '0;
      dev_sel   <= '0;
    end else if (glb_we) begin
      glb_valid[glb_addr] <= 1'b1;
      if (index_reg == IDX_DEVSEL) begin
        dev_sel <= glb_wdata;
      end
    end
  end

  scrf_ram #(
    .WIDTH (8),
    .DEPTH (GLOBAL_REG_COUNT)
  ) u_glb_ram (
    .clk   (clk),
    .we    (glb_we),
    .waddr (glb_addr),
    .wdata (glb_wdata),
    .re    (cmd.accept),
    .raddr (glb_addr),
    .rdata (glb_rdata)
  );

  // Clearing pass counter over the device store.
  assign sts.clear_last = (clr_cnt == DEV_AW'(DEV_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr && !sts.clear_last) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Device store: defaults during the clearing pass, then guarded writes.
  assign dev_we    = cmd.clear_wr ||
                     (data_wr && !is_glb && !dev_write_blocked(dev_sel, index_reg, chip_variant));
  assign dev_waddr = cmd.clear_wr ? clr_cnt : dev_addr;
  assign dev_wdata = cmd.clear_wr ? dev_default(clr_cnt) : wdata_q;

  scrf_ram #(
    .WIDTH (8),
    .DEPTH (DEV_DEPTH)
  ) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (dev_waddr),
    .wdata (dev_wdata),
    .re    (cmd.accept),
    .raddr (dev_addr),
    .rdata (dev_rdata)
  );

  // Read value selection.
  assign glb_value = glb_valid[glb_addr] ? glb_rdata : glb_default(glb_addr);

  always_comb begin
    if (is_wr || !mode_open) begin
      rd_value = IDLE_BYTE;
    end else if (port_q == PORT_INDEX) begin
      rd_value = index_reg;
    end else if (is_glb) begin
      rd_value = (index_reg == IDX_CHIP_ID) ? 8'(chip_variant) : glb_value;
    end else if (!dev_in_range) begin
      rd_value = IDLE_BYTE;
    end else begin
      rd_value = dev_rdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data   <= rd_value;
      config_open <= mode_open_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/superio_config_register_file.sv -----
// Plug-and-play configuration register file of a multi-function I/O chip.
// Each transfer on the item channel is one host bus access (command: read or
// write; port_select: index or data port; write_data). Each access gives one
// transfer on the result channel with read_data and config_open, in order.
// Two index writes of 0x55 open configuration mode, an index write of 0xAA
// closes it; reads return 0xFF while closed and on every write.
// Per access, the transfer cycle starts the registered read of the global and
// device memories; in ST_EXEC, once the result register is free, the access is
// applied and the result register loaded. The result shows in the cycle after
// that, and a new access can be taken then, but none while one is in ST_EXEC.
// If the receiver stalls, the result register holds its value and the block
// still takes one more access, which then waits until the result drains.
// After reset item_stall stays high while the device memory is filled with its
// defaults, one entry a cycle. chip_variant is written through chip_variant_we
// and chip_variant_wdata; the user must keep this between accesses (not enforced).
// Depends on scrf_pkg, scrf_ctrl, scrf_dpath and scrf_ram.
`default_nettype none

module superio_config_register_file (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       chip_variant_we,
  input  wire logic [1:0] chip_variant_wdata,
  input  wire logic       item_valid,
  output      logic       item_stall,
  input  wire logic       command,
  input  wire logic       port_select,
  input  wire logic [7:0] write_data,
  output      logic       result_valid,
  input  wire logic       result_stall,
  output      logic [7:0] read_data,
  output      logic       config_open
);

  import scrf_pkg::*;

  scrf_cmd_t cmd;
  scrf_sts_t sts;

  // Access sequencing.
  scrf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Registers, stores and result.
  scrf_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .chip_variant_we    (chip_variant_we),
    .chip_variant_wdata (chip_variant_wdata),
    .command            (command),
    .port_select        (port_select),
    .write_data         (write_data),
    .read_data          (read_data),
    .config_open        (config_open)
  );

endmodule

`default_nettype wire

// ----- rtl/core/scrf_checker.sv -----
// Port-level checker of the configuration register file and its bind.
// Depends on superio_config_register_file_macros.svh.
`default_nettype none

`include "superio_config_register_file_macros.svh"

module scrf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [7:0] read_data,
  input wire logic       config_open
);

  // A stalled result holds.
  `SCRF_ASSERT_NEXT(a_result_hold,
    result_valid && result_stall,
    result_valid && $stable(read_data) && $stable(config_open),
    "stalled result changed")

  // The block is busy in the cycle after taking an access.
  `SCRF_ASSERT_NEXT(a_busy_after_transfer,
    item_valid && !item_stall,
    item_stall,
    "access taken in back-to-back cycles")

  // With the mode closed after an access, the result byte is idle.
  `SCRF_ASSERT_SAME(a_closed_idle_byte,
    result_valid && !config_open,
    read_data == 8'hFF,
    "read data not idle while closed")

  // The clearing pass holds off accesses right after reset.
  `SCRF_ASSERT_SAME(a_clear_after_reset,
    $past(rst),
    item_stall,
    "access possible during clearing pass")

endmodule

bind superio_config_register_file scrf_checker u_scrf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .read_data    (read_data),
  .config_open  (config_open)
);

`default_nettype wire

// ----- tb/scrf_access_checker.sv -----
`timescale 1ns / 1ps
// Checker of the configuration register file: keeps its own copy of the register state,
// predicts the result of every accepted bus access and compares it with the result channel.
// Depends on scrf_pkg for the special bytes, register indexes and store sizes.

module scrf_access_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       chip_variant_we,
  input  logic [1:0] chip_variant_wdata,
  input  logic       item_valid,
  input  logic       item_stall,
  input  logic       command,
  input  logic       port_select,
  input  logic [7:0] write_data,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] read_data,
  input  logic       config_open,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  import scrf_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       open;
  } bus_result_t;

  // Devices below this number keep their interrupt and DMA bank (0x70-0x7F) read-only.
  localparam int         FIRST_FREE_DEV = 4;
  localparam logic [7:0] OPTIONAL_DEV   = 8'd9;
  localparam logic [3:0] IRQ_DMA_BANK   = 4'h7;

  logic [1:0]  variant;
  logic [7:0]  glb_shadow [GLOBAL_REG_COUNT];
  logic [7:0]  dev_shadow [DEV_DEPTH];
  logic        mode_shadow;
  logic        unlock_half;
  logic [7:0]  index_shadow;
  bus_result_t awaited_results [$];
  int          fails = 0;
  int          matched = 0;

  // Power-up contents of both stores and of the unlock logic.
  task automatic load_defaults();
    for (int i = 0; i < GLOBAL_REG_COUNT; i++) glb_shadow[i] = 8'h00;
    for (int i = 0; i < DEV_DEPTH; i++) dev_shadow[i] = 8'h00;
    glb_shadow['h03] = 8'h03; glb_shadow['h20] = 8'h03; glb_shadow['h21] = 8'h01;
    glb_shadow['h22] = 8'h39; glb_shadow['h24] = 8'h04; glb_shadow['h26] = 8'hF0;
    glb_shadow['h27] = 8'h03;
    // Store address is the device number times 256 plus the register index.
    dev_shadow['h030] = 8'h01; dev_shadow['h060] = 8'h03; dev_shadow['h061] = 8'hF0;
    dev_shadow['h070] = 8'h06; dev_shadow['h074] = 8'h02; dev_shadow['h0F0] = 8'h0E;
    dev_shadow['h0F2] = 8'hFF;
    dev_shadow['h160] = 8'h01; dev_shadow['h161] = 8'hF0; dev_shadow['h162] = 8'h03;
    dev_shadow['h163] = 8'hF6; dev_shadow['h170] = 8'h0E; dev_shadow['h1F0] = 8'h0C;
    dev_shadow['h260] = 8'h01; dev_shadow['h261] = 8'h70; dev_shadow['h262] = 8'h03;
    dev_shadow['h263] = 8'h76; dev_shadow['h270] = 8'h0F;
    dev_shadow['h330] = 8'h01; dev_shadow['h360] = 8'h03; dev_shadow['h361] = 8'h78;
    dev_shadow['h370] = 8'h07; dev_shadow['h374] = 8'h04; dev_shadow['h3F0] = 8'h3C;
    dev_shadow['h430] = 8'h01; dev_shadow['h460] = 8'h03; dev_shadow['h461] = 8'hF8;
    dev_shadow['h470] = 8'h04; dev_shadow['h4F0] = 8'h03;
    dev_shadow['h530] = 8'h01; dev_shadow['h560] = 8'h02; dev_shadow['h561] = 8'hF8;
    dev_shadow['h570] = 8'h03; dev_shadow['h574] = 8'h04; dev_shadow['h5F1] = 8'h02;
    dev_shadow['h5F2] = 8'h03;
    dev_shadow['h663] = 8'h70; dev_shadow['h6F4] = 8'h03;
    dev_shadow['h730] = 8'h01; dev_shadow['h761] = 8'h60; dev_shadow['h770] = 8'h01;
    mode_shadow  = 1'b0;
    unlock_half  = 1'b0;
    index_shadow = 8'h00;
  endtask

  // A device write is dropped for missing devices, read-only devices, the protected
  // bank of the low devices, and device 9 on the variant that lacks it.
  function automatic logic dev_locked(input logic [7:0] dev, input logic [7:0] rg);
    if (int'(dev) >= DEVICE_COUNT) return 1'b1;
    if (rg[7:4] == IRQ_DMA_BANK && int'(dev) < FIRST_FREE_DEV) return 1'b1;
    if (dev == 8'd1 || dev == 8'd2 || dev == 8'd6 || dev == 8'd7) return 1'b1;
    if (dev == OPTIONAL_DEV && variant != VARIANT_FULL) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one bus access to the shadow state and gives the result it must produce.
  task automatic decode_bus_access(input logic cmd, input logic port, input logic [7:0] data,
                                   output bus_result_t res);
    logic [7:0] dev;
    int         reg_i;
    dev       = glb_shadow[IDX_DEVSEL];
    reg_i     = int'(index_shadow);
    res.rdata = IDLE_BYTE;
    if (cmd == CMD_WRITE && port == PORT_INDEX) begin
      if (!mode_shadow) begin
        if (data == UNLOCK_BYTE) begin
          if (unlock_half) begin
            mode_shadow = 1'b1;
            unlock_half = 1'b0;
          end else begin
            unlock_half = 1'b1;
          end
        end else begin
          unlock_half = 1'b0;
        end
      end else if (data == LOCK_BYTE) begin
        mode_shadow = 1'b0;
      end else begin
        index_shadow = data;
      end
    end else if (cmd == CMD_WRITE) begin
      if (mode_shadow) begin
        if (reg_i < GLOBAL_REG_COUNT) begin
          if (index_shadow == IDX_POWER) begin
            glb_shadow[reg_i] = data & REG3_MASK;
          end else if (index_shadow != IDX_CHIP_ID && index_shadow != IDX_CHIP_RV) begin
            glb_shadow[reg_i] = data;
          end
        end else if (!dev_locked(dev, index_shadow)) begin
          dev_shadow[int'(dev) * 256 + reg_i] = data;
        end
      end
    end else if (mode_shadow) begin
      if (port == PORT_INDEX) begin
        res.rdata = index_shadow;
      end else if (reg_i < GLOBAL_REG_COUNT) begin
        res.rdata = (index_shadow == IDX_CHIP_ID) ? 8'(variant) : glb_shadow[reg_i];
      end else if (int'(dev) < DEVICE_COUNT) begin
        res.rdata = dev_shadow[int'(dev) * 256 + reg_i];
      end
    end
    res.open = mode_shadow;
  endtask

  // Result transfers are matched before new accesses are queued, so a stray result
  // can never be paired with an access taken at the same edge.
  always @(posedge clk) begin : monitor
    bus_result_t want;
    if (rst) begin
      variant = VARIANT_FULL;
      load_defaults();
      awaited_results.delete();
    end else begin
      if (chip_variant_we) variant = chip_variant_wdata;
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result transfer with none expected, read_data %02h config_open %0b",
                   $time, read_data, config_open);
        end else begin
          want = awaited_results.pop_front();
          matched++;
          if (read_data !== want.rdata) begin
            fails++;
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want.rdata, read_data);
          end
          if (config_open !== want.open) begin
            fails++;
            $display("%0t: config_open mismatch, expected %0b, actual %0b",
                     $time, want.open, config_open);
          end
        end
      end
      if (item_valid && !item_stall) begin
        decode_bus_access(command, port_select, write_data, want);
        awaited_results.push_back(want);
      end
    end
    fail_count <= fails;
    pending    <= awaited_results.size();
    checked    <= matched;
  end

endmodule

// ----- tb/superio_config_register_file_test.sv -----
`timescale 1ns / 1ps
// Top of the configuration register file testbench: clock, reset, bus access stimulus,
// pacing of both channels and the verdict. Depends on scrf_pkg, the block and scrf_access_checker.

module superio_config_register_file_test;
  import scrf_pkg::*;

  localparam int         ACCESSES_PER_PHASE = 290;
  localparam logic [1:0] VARIANT_NO_DEV9    = 2'd2;
  localparam logic [7:0] IDX_DEV_MODE2      = 8'hF2;
  localparam logic [7:0] IDX_BANK7_BASE     = 8'h70;

  logic       clk;
  logic       rst = 1'b1;
  logic       chip_variant_we = 1'b0;
  logic [1:0] chip_variant_wdata = VARIANT_FULL;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       command = CMD_READ;
  logic       port_select = PORT_INDEX;
  logic [7:0] write_data = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] read_data;
  logic       config_open;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int accesses_sent = 0;
  int fail_count;
  int pending;
  int checked;

  superio_config_register_file u_top (
    .clk                (clk),
    .rst                (rst),
    .chip_variant_we    (chip_variant_we),
    .chip_variant_wdata (chip_variant_wdata),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .command            (command),
    .port_select        (port_select),
    .write_data         (write_data),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .read_data          (read_data),
    .config_open        (config_open)
  );

  scrf_access_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .chip_variant_we    (chip_variant_we),
    .chip_variant_wdata (chip_variant_wdata),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .command            (command),
    .port_select        (port_select),
    .write_data         (write_data),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .read_data          (read_data),
    .config_open        (config_open),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  // One bus access: optional idle cycles, then hold the payload until the transfer.
  task automatic host_access(input logic cmd, input logic port, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    command     <= cmd;
    port_select <= port;
    write_data  <= data;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    accesses_sent++;
  endtask

  task automatic noise_access();
    host_access(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_variant(input logic [1:0] v);
    chip_variant_we    <= 1'b1;
    chip_variant_wdata <= v;
    @(posedge clk);
    chip_variant_we    <= 1'b0;
  endtask

  // Register index biased toward the ones with special handling.
  function automatic logic [7:0] pick_index();
    int p;
    p = $urandom_range(99);
    if (p < 20) begin
      case ($urandom_range(4))
        0:       return IDX_POWER;
        1:       return IDX_DEVSEL;
        2:       return IDX_CHIP_ID;
        3:       return IDX_CHIP_RV;
        default: return IDX_DEV_MODE2;
      endcase
    end
    if (p < 40) return IDX_BANK7_BASE | 8'($urandom_range(15));
    if (p < 70) return 8'($urandom_range(GLOBAL_REG_COUNT - 1));
    return 8'($urandom_range(255, GLOBAL_REG_COUNT));
  endfunction

  // Mostly existing devices, sometimes just past the end, rarely anything.
  function automatic logic [7:0] pick_device();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 8'($urandom_range(DEVICE_COUNT - 1));
    if (p < 90) return 8'($urandom_range(15, DEVICE_COUNT));
    return 8'($urandom_range(255));
  endfunction

  // One configuration session: unlock, a run of register accesses, usually a lock.
  task automatic run_session();
    int pick;
    int ops;
    pick = $urandom_range(99);
    if (pick < 80) begin
      host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
      host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
    end else if (pick < 92) begin
      // Broken unlock sequence, then a good one.
      host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
      host_access(CMD_WRITE, PORT_INDEX, 8'($urandom_range(255)));
      host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
      host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
    end else begin
      noise_access();
    end
    ops = $urandom_range(24, 4);
    repeat (ops) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        host_access(CMD_WRITE, PORT_INDEX, pick_index());
      end else if (pick < 55) begin
        host_access(CMD_READ, PORT_DATA, 8'($urandom_range(255)));
      end else if (pick < 78) begin
        host_access(CMD_WRITE, PORT_DATA, 8'($urandom_range(255)));
      end else if (pick < 86) begin
        host_access(CMD_WRITE, PORT_INDEX, IDX_DEVSEL);
        host_access(CMD_WRITE, PORT_DATA, pick_device());
      end else if (pick < 93) begin
        host_access(CMD_READ, PORT_INDEX, 8'($urandom_range(255)));
      end else begin
        noise_access();
      end
    end
    if ($urandom_range(99) < 85) host_access(CMD_WRITE, PORT_INDEX, LOCK_BYTE);
  endtask

  // One pacing phase with its own chip variant; the sender drains once halfway.
  task automatic run_phase(input int send_pct, input int recv_pct, input logic [1:0] v);
    int target;
    int midway;
    logic drained;
    wait_drained();
    set_variant(v);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    target        = accesses_sent + ACCESSES_PER_PHASE;
    midway        = accesses_sent + ACCESSES_PER_PHASE / 2;
    drained       = 1'b0;
    while (accesses_sent < target) begin
      run_session();
      if (!drained && accesses_sent >= midway) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_variant(VARIANT_FULL);

    // Directed accesses: closed-mode behavior, unlock sequence, special registers.
    host_access(CMD_READ,  PORT_INDEX, 8'h00);
    host_access(CMD_WRITE, PORT_DATA,  8'h77);
    host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
    host_access(CMD_WRITE, PORT_INDEX, 8'h3C);
    host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
    host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
    host_access(CMD_READ,  PORT_INDEX, 8'h00);
    // The unlock byte while open only selects a register.
    host_access(CMD_WRITE, PORT_INDEX, UNLOCK_BYTE);
    host_access(CMD_READ,  PORT_INDEX, 8'h00);
    host_access(CMD_WRITE, PORT_INDEX, IDX_DEV_MODE2);
    host_access(CMD_READ,  PORT_DATA,  8'h00);
    host_access(CMD_WRITE, PORT_INDEX, IDX_CHIP_ID);
    host_access(CMD_WRITE, PORT_DATA,  8'h00);
    host_access(CMD_READ,  PORT_DATA,  8'h00);
    host_access(CMD_WRITE, PORT_INDEX, IDX_POWER);
    host_access(CMD_WRITE, PORT_DATA,  8'hFF);
    host_access(CMD_READ,  PORT_DATA,  8'h00);
    // Device 9 exists on the full variant.
    host_access(CMD_WRITE, PORT_INDEX, IDX_DEVSEL);
    host_access(CMD_WRITE, PORT_DATA,  8'd9);
    host_access(CMD_WRITE, PORT_INDEX, IDX_BANK7_BASE);
    host_access(CMD_WRITE, PORT_DATA,  8'hA5);
    host_access(CMD_READ,  PORT_DATA,  8'h00);
    host_access(CMD_WRITE, PORT_INDEX, LOCK_BYTE);
    host_access(CMD_READ,  PORT_DATA,  8'h00);

    run_phase(0, 0, VARIANT_FULL);
    run_phase(62, 0, VARIANT_NO_DEV9);
    run_phase(0, 62, VARIANT_FULL);
    run_phase(24, 24, VARIANT_NO_DEV9);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Ran %0d bus accesses and checked %0d results over four pacing phases,",
             accesses_sent, checked);
    $display("with chip variants 2 and 3 and full sessions mixed with random accesses.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
